@@ rtl/token_bucket_rate_limiter_core_assert.svh @@
// Assertion macros shared by the token bucket limiter RTL.
`ifndef TOKEN_BUCKET_RATE_LIMITER_CORE_ASSERT_SVH
`define TOKEN_BUCKET_RATE_LIMITER_CORE_ASSERT_SVH
`ifndef SYNTH
// Check that prop holds at every clock edge outside reset.
`define TBRL_ASSERT(label, clk, rst_n, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("tbrl assertion failed");
// Check that cond is never true at a clock edge outside reset.
`define TBRL_ASSERT_NEVER(label, clk, rst_n, cond) \
	label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
		else $error("tbrl forbidden condition seen");
`else
`define TBRL_ASSERT(label, clk, rst_n, prop)
`define TBRL_ASSERT_NEVER(label, clk, rst_n, cond)
`endif
`endif

@@ rtl/tbrl_pkg.sv @@
// Types and constants of the token bucket rate limiter.
package tbrl_pkg;

	localparam int CAP_W      = 16;
	localparam int RATE_W     = 32;
	localparam int CMD_W      = 2;
	localparam int REG_IDX_W  = 1;
	localparam int CFG_DATA_W = 32;

	localparam logic [CAP_W-1:0]  CAPACITY_RST   = 16'd16;
	localparam logic [RATE_W-1:0] TOKEN_RATE_RST = 32'd65536;

	typedef enum logic [CMD_W-1:0] {
		CMD_REQUEST = 2'd0,
		CMD_QUERY   = 2'd1,
		CMD_RESET   = 2'd2
	} cmd_t;

	typedef enum logic [REG_IDX_W-1:0] {
		REG_CAPACITY   = 1'd0,
		REG_TOKEN_RATE = 1'd1
	} reg_idx_t;

	typedef struct packed {
		logic [CAP_W-1:0]  capacity;
		logic [RATE_W-1:0] token_rate;
	} bucket_cfg_t;

endpackage

@@ rtl/tbrl_item_if.sv @@
// Input channel: command word with a millisecond timestamp.
interface tbrl_item_if #(
	parameter int TIME_BITS = 48
);
	logic                         valid;
	logic                         ready;
	logic [tbrl_pkg::CMD_W-1:0]   cmd;
	logic [TIME_BITS-1:0]         now_ms;

	modport source (output valid, output cmd, output now_ms, input ready);
	modport sink (input valid, input cmd, input now_ms, output ready);
endinterface

@@ rtl/tbrl_result_if.sv @@
// Result channel: grant flag, whole tokens and the two counters.
interface tbrl_result_if #(
	parameter int COUNT_BITS = 48
);
	logic                          valid;
	logic                          ready;
	logic                          allowed;
	logic [tbrl_pkg::CAP_W-1:0]    available;
	logic [COUNT_BITS-1:0]         allowed_total;
	logic [COUNT_BITS-1:0]         rejected_total;

	modport source (output valid, output allowed, output available,
		output allowed_total, output rejected_total, input ready);
	modport sink (input valid, input allowed, input available,
		input allowed_total, input rejected_total, output ready);
endinterface

@@ rtl/tbrl_cfg_if.sv @@
// Configuration write channel: register index and write data.
interface tbrl_cfg_if;
	logic                            valid;
	logic                            ready;
	logic [tbrl_pkg::REG_IDX_W-1:0]  index;
	logic [tbrl_pkg::CFG_DATA_W-1:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

@@ rtl/tbrl_bucket.sv @@
// Bucket state and its combinational refill, take and count update.
module tbrl_bucket #(
	parameter int FRAC_BITS  = 16,
	parameter int TIME_BITS  = 48,
	parameter int COUNT_BITS = 48
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         fire,
	input  tbrl_pkg::cmd_t               cmd,
	input  logic [TIME_BITS-1:0]         now_ms,
	input  tbrl_pkg::bucket_cfg_t        cfg,
	output logic                         allowed,
	output logic [tbrl_pkg::CAP_W-1:0]   available,
	output logic [COUNT_BITS-1:0]        allowed_total,
	output logic [COUNT_BITS-1:0]        rejected_total
);
	localparam int LVL_W  = tbrl_pkg::CAP_W + FRAC_BITS;
	localparam int PROD_W = 2 * tbrl_pkg::RATE_W;
	localparam logic [LVL_W-1:0] ONE_TOKEN = LVL_W'(1) << FRAC_BITS;

	logic [LVL_W-1:0]      level_q;
	logic [TIME_BITS-1:0]  last_q;
	logic                  base_q;
	logic [COUNT_BITS-1:0] grant_q;
	logic [COUNT_BITS-1:0] refuse_q;

	logic [LVL_W-1:0]      level_d;
	logic [TIME_BITS-1:0]  last_d;
	logic                  base_d;
	logic [COUNT_BITS-1:0] grant_d;
	logic [COUNT_BITS-1:0] refuse_d;

	logic [LVL_W-1:0]      cap_lvl;
	logic [TIME_BITS-1:0]  elapsed;
	logic                  elapsed_hi;
	logic [PROD_W-1:0]     gain;
	logic                  rate_nz;
	logic                  refill_sat;
	logic [LVL_W:0]        sum;
	logic [LVL_W-1:0]      filled;
	logic [LVL_W-1:0]      refilled;
	logic [TIME_BITS-1:0]  last_ref;
	logic                  ok;

	assign cap_lvl    = {cfg.capacity, {FRAC_BITS{1'b0}}};
	assign elapsed    = now_ms - last_q;
	assign elapsed_hi = (elapsed >> tbrl_pkg::RATE_W) != '0;
	assign gain       = PROD_W'(elapsed[tbrl_pkg::RATE_W-1:0]) * PROD_W'(cfg.token_rate);
	assign rate_nz    = cfg.token_rate != '0;
	// Gain above the full level (or a huge gap at any nonzero rate) pins the bucket full
	assign refill_sat = rate_nz && (elapsed_hi || (gain > PROD_W'(cap_lvl)));
	assign sum        = {1'b0, level_q} + {1'b0, gain[LVL_W-1:0]};
	assign filled     = (sum > {1'b0, cap_lvl}) ? cap_lvl : sum[LVL_W-1:0];

	// Refill: first stamp or a backward stamp only moves the baseline
	always_comb begin
		refilled = level_q;
		last_ref = last_q;
		if (!base_q || now_ms < last_q) begin
			last_ref = now_ms;
		end else if (now_ms != last_q) begin
			refilled = refill_sat ? cap_lvl : filled;
			last_ref = now_ms;
		end
	end

	always_comb begin
		level_d  = level_q;
		last_d   = last_q;
		base_d   = base_q;
		grant_d  = grant_q;
		refuse_d = refuse_q;
		ok       = 1'b0;
		case (cmd)
			tbrl_pkg::CMD_REQUEST: begin
				last_d = last_ref;
				base_d = 1'b1;
				if (refilled >= ONE_TOKEN) begin
					level_d = refilled - ONE_TOKEN;
					grant_d = (grant_q == '1) ? grant_q : grant_q + 1'b1;
					ok      = 1'b1;
				end else begin
					level_d  = refilled;
					refuse_d = (refuse_q == '1) ? refuse_q : refuse_q + 1'b1;
				end
			end
			tbrl_pkg::CMD_QUERY: begin
				level_d = refilled;
				last_d  = last_ref;
				base_d  = 1'b1;
			end
			tbrl_pkg::CMD_RESET: begin
				level_d  = cap_lvl;
				base_d   = 1'b0;
				grant_d  = '0;
				refuse_d = '0;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			level_q  <= {tbrl_pkg::CAPACITY_RST, {FRAC_BITS{1'b0}}};
			last_q   <= '0;
			base_q   <= 1'b0;
			grant_q  <= '0;
			refuse_q <= '0;
		end else if (fire) begin
			level_q  <= level_d;
			last_q   <= last_d;
			base_q   <= base_d;
			grant_q  <= grant_d;
			refuse_q <= refuse_d;
		end
	end

	assign allowed        = ok;
	assign available      = level_d[LVL_W-1:FRAC_BITS];
	assign allowed_total  = grant_d;
	assign rejected_total = refuse_d;
endmodule

@@ rtl/token_bucket_rate_limiter_core.sv @@
// Top level of the token bucket rate limiter.
// Usage:
//   item   (sink)   : cmd (0 request, 1 query, 2 reset) and now_ms; one word per item.
//   result (source) : allowed, available, allowed_total, rejected_total; one word per item.
//   cfg    (sink)   : index 0 writes capacity, index 1 writes token_rate (Q.FRAC_BITS).
//                     Always ready; write only while no item is in flight.
// Flow: an accepted word lands in the input register; once the output register is
//   free or being drained it is processed against the bucket state and its result
//   is loaded into the output register.
// Throughput: one item per cycle while result.ready is high; the refill subtract, a
//   32x32 multiply, the clamp and the take all fit between the input and output
//   registers, and the bucket state updates on the same edge that loads the result.
// Stall: while the result sits untaken the input register still holds one item;
//   item.ready drops only once both registers are full.
// Reset: arst_n clears both handshake stages, fills the bucket to the reset
//   capacity, clears the counters and the time baseline, and restores the
//   register defaults (capacity 16, token_rate 1.0 token per ms).
`include "token_bucket_rate_limiter_core_assert.svh"
module token_bucket_rate_limiter_core #(
	parameter int FRAC_BITS  = 16,
	parameter int TIME_BITS  = 48,
	parameter int COUNT_BITS = 48
) (
	input  logic                 clk,
	input  logic                 arst_n,
	tbrl_item_if.sink            item,
	tbrl_result_if.source        result,
	tbrl_cfg_if.sink             cfg
);
	// Configuration registers
	tbrl_pkg::bucket_cfg_t cfg_q;

	// Input stage
	logic                  valid_s1;
	tbrl_pkg::cmd_t        cmd_s1;
	logic [TIME_BITS-1:0]  now_s1;

	// Output stage
	logic                          out_valid_q;
	logic                          allowed_q;
	logic [tbrl_pkg::CAP_W-1:0]    available_q;
	logic [COUNT_BITS-1:0]         allowed_total_q;
	logic [COUNT_BITS-1:0]         rejected_total_q;

	logic                          advance;
	logic                          nxt_allowed;
	logic [tbrl_pkg::CAP_W-1:0]    nxt_available;
	logic [COUNT_BITS-1:0]         nxt_allowed_total;
	logic [COUNT_BITS-1:0]         nxt_rejected_total;

	// Config writes land immediately
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.capacity   <= tbrl_pkg::CAPACITY_RST;
			cfg_q.token_rate <= tbrl_pkg::TOKEN_RATE_RST;
		end else if (cfg.valid) begin
			case (tbrl_pkg::reg_idx_t'(cfg.index))
				tbrl_pkg::REG_CAPACITY:   cfg_q.capacity   <= cfg.data[tbrl_pkg::CAP_W-1:0];
				tbrl_pkg::REG_TOKEN_RATE: cfg_q.token_rate <= cfg.data[tbrl_pkg::RATE_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// Process the held word when the output register is free or being drained
	assign advance    = valid_s1 && (!out_valid_q || result.ready);
	assign item.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item.valid && item.ready) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	// Payload only loads on accept; no reset needed
	always_ff @(posedge clk) begin
		if (item.valid && item.ready) begin
			cmd_s1 <= tbrl_pkg::cmd_t'(item.cmd);
			now_s1 <= item.now_ms;
		end
	end

	tbrl_bucket #(
		.FRAC_BITS  (FRAC_BITS),
		.TIME_BITS  (TIME_BITS),
		.COUNT_BITS (COUNT_BITS)
	) u_bucket (
		.clk            (clk),
		.arst_n         (arst_n),
		.fire           (advance),
		.cmd            (cmd_s1),
		.now_ms         (now_s1),
		.cfg            (cfg_q),
		.allowed        (nxt_allowed),
		.available      (nxt_available),
		.allowed_total  (nxt_allowed_total),
		.rejected_total (nxt_rejected_total)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Hold the result until taken; load a fresh one on advance
	always_ff @(posedge clk) begin
		if (advance) begin
			allowed_q        <= nxt_allowed;
			available_q      <= nxt_available;
			allowed_total_q  <= nxt_allowed_total;
			rejected_total_q <= nxt_rejected_total;
		end
	end

	assign result.valid          = out_valid_q;
	assign result.allowed        = allowed_q;
	assign result.available      = available_q;
	assign result.allowed_total  = allowed_total_q;
	assign result.rejected_total = rejected_total_q;

	`TBRL_ASSERT(a_accept_fills_s1, clk, arst_n, (item.valid && item.ready) |=> valid_s1)
	`TBRL_ASSERT_NEVER(a_no_accept_when_full, clk, arst_n, valid_s1 && out_valid_q && !result.ready && item.ready)
	`TBRL_ASSERT(a_grant_counted, clk, arst_n, (result.valid && result.allowed) |-> (result.allowed_total != '0))
	`TBRL_ASSERT(a_reset_clears_counts, clk, arst_n, (advance && cmd_s1 == tbrl_pkg::CMD_RESET) |=> (result.allowed_total == '0 && result.rejected_total == '0))
endmodule

@@ verif/token_bucket_rate_limiter_core_test.sv @@
// Self-checking testbench of the token bucket limiter: directed table, then random phases.
`timescale 1ns / 100ps

module token_bucket_rate_limiter_core_test;

	localparam int FRAC_W  = 16;
	localparam int TIME_W  = 48;
	localparam int COUNT_W = 48;

	localparam int LIMIT_CYCLES  = 400000;
	localparam int SETTLE_CYCLES = 4;
	localparam int TAIL_CYCLES   = 16;
	localparam int HOLD_CYCLES   = 150;
	localparam int PHASES        = 6;
	localparam int PHASE_WORDS   = 108;
	localparam int LOUD_LIMIT    = 10;

	// Command code the block does not define; it must leave the state alone.
	localparam logic [tbrl_pkg::CMD_W-1:0] CMD_SPARE = 2'd3;
	localparam logic [TIME_W-1:0]          MS_TOP    = '1;

	typedef struct packed {
		logic                         allowed;
		logic [tbrl_pkg::CAP_W-1:0]   available;
		logic [COUNT_W-1:0]           allowed_total;
		logic [COUNT_W-1:0]           rejected_total;
	} bucket_word_t;

	typedef enum bit {ROW_ITEM, ROW_WRITE} row_kind_t;

	typedef enum logic [1:0] {RX_OPEN, RX_COIN, RX_SPARSE, RX_TOGGLE} rx_mode_t;

	// One step of the directed plan: an item word (sent reps times) or a register write.
	typedef struct packed {
		row_kind_t                    kind;
		logic [tbrl_pkg::CMD_W-1:0]   cmd;
		tbrl_pkg::reg_idx_t           idx;
		logic [TIME_W-1:0]            value;
		logic [3:0]                   reps;
		bit                           typed;
		bucket_word_t                 want;
	} plan_row_t;

	localparam bucket_word_t NO_WANT = '0;

	// Directed plan, starting from the reset registers (capacity 16, 1.0 token per ms).
	// Rows with typed set carry the result word read straight off the bucket rules.
	localparam plan_row_t DIRECTED [0:27] = '{
		// first word only records the baseline, then takes from a full bucket
		'{ROW_ITEM, tbrl_pkg::CMD_REQUEST, tbrl_pkg::REG_CAPACITY, 48'd100, 4'd1,
			1'b1, '{1'b1, 16'd15, 48'd1, 48'd0}},
		// equal timestamp: no refill
		'{ROW_ITEM, tbrl_pkg::CMD_QUERY, tbrl_pkg::REG_CAPACITY, 48'd100, 4'd1,
			1'b1, '{1'b0, 16'd15, 48'd1, 48'd0}},
		// time runs backwards: baseline moves, nothing gained
		'{ROW_ITEM, tbrl_pkg::CMD_REQUEST, tbrl_pkg::REG_CAPACITY, 48'd90, 4'd1,
			1'b1, '{1'b1, 16'd14, 48'd2, 48'd0}},
		'{ROW_ITEM, tbrl_pkg::CMD_REQUEST, tbrl_pkg::REG_CAPACITY, 48'd95, 4'd1,
			1'b0, NO_WANT},
		// unused command: report the state untouched
		'{ROW_ITEM, CMD_SPARE, tbrl_pkg::REG_CAPACITY, MS_TOP, 4'd1,
			1'b1, '{1'b0, 16'd15, 48'd3, 48'd0}},
		'{ROW_ITEM, tbrl_pkg::CMD_RESET, tbrl_pkg::REG_CAPACITY, MS_TOP, 4'd1,
			1'b1, '{1'b0, 16'd16, 48'd0, 48'd0}},
		'{ROW_ITEM, tbrl_pkg::CMD_QUERY, tbrl_pkg::REG_CAPACITY, MS_TOP, 4'd1,
			1'b1, '{1'b0, 16'd16, 48'd0, 48'd0}},
		'{ROW_ITEM, tbrl_pkg::CMD_REQUEST, tbrl_pkg::REG_CAPACITY, 48'd0, 4'd1,
			1'b1, '{1'b1, 16'd15, 48'd1, 48'd0}},
		'{ROW_ITEM, tbrl_pkg::CMD_RESET, tbrl_pkg::REG_CAPACITY, 48'd0, 4'd1,
			1'b1, '{1'b0, 16'd16, 48'd0, 48'd0}},
		// lower the capacity under a full bucket: clamp waits for time to pass
		'{ROW_WRITE, tbrl_pkg::CMD_QUERY, tbrl_pkg::REG_CAPACITY, 48'd4, 4'd0,
			1'b0, NO_WANT},
		'{ROW_ITEM, tbrl_pkg::CMD_QUERY, tbrl_pkg::REG_CAPACITY, 48'd1000, 4'd1,
			1'b1, '{1'b0, 16'd16, 48'd0, 48'd0}},
		'{ROW_ITEM, tbrl_pkg::CMD_QUERY, tbrl_pkg::REG_CAPACITY, 48'd1000, 4'd1,
			1'b1, '{1'b0, 16'd16, 48'd0, 48'd0}},
		'{ROW_ITEM, tbrl_pkg::CMD_QUERY, tbrl_pkg::REG_CAPACITY, 48'd1001, 4'd1,
			1'b1, '{1'b0, 16'd4, 48'd0, 48'd0}},
		// zero rate: drain and stay empty however long the gap
		'{ROW_WRITE, tbrl_pkg::CMD_QUERY, tbrl_pkg::REG_TOKEN_RATE, 48'd0, 4'd0,
			1'b0, NO_WANT},
		'{ROW_ITEM, tbrl_pkg::CMD_REQUEST, tbrl_pkg::REG_CAPACITY, 48'd5000, 4'd1,
			1'b1, '{1'b1, 16'd3, 48'd1, 48'd0}},
		'{ROW_ITEM, tbrl_pkg::CMD_REQUEST, tbrl_pkg::REG_CAPACITY, 48'd6000, 4'd3,
			1'b0, NO_WANT},
		'{ROW_ITEM, tbrl_pkg::CMD_REQUEST, tbrl_pkg::REG_CAPACITY, MS_TOP, 4'd1,
			1'b1, '{1'b0, 16'd0, 48'd4, 48'd1}},
		// largest capacity and rate: one ms past the baseline fills the bucket
		'{ROW_WRITE, tbrl_pkg::CMD_QUERY, tbrl_pkg::REG_CAPACITY, 48'd65535, 4'd0,
			1'b0, NO_WANT},
		'{ROW_WRITE, tbrl_pkg::CMD_QUERY, tbrl_pkg::REG_TOKEN_RATE, 48'hFFFF_FFFF, 4'd0,
			1'b0, NO_WANT},
		'{ROW_ITEM, tbrl_pkg::CMD_REQUEST, tbrl_pkg::REG_CAPACITY, 48'd0, 4'd1,
			1'b1, '{1'b0, 16'd0, 48'd4, 48'd2}},
		'{ROW_ITEM, tbrl_pkg::CMD_REQUEST, tbrl_pkg::REG_CAPACITY, 48'd1, 4'd1,
			1'b1, '{1'b1, 16'd65534, 48'd5, 48'd2}},
		// zero capacity empties the bucket at the next tick
		'{ROW_WRITE, tbrl_pkg::CMD_QUERY, tbrl_pkg::REG_CAPACITY, 48'd0, 4'd0,
			1'b0, NO_WANT},
		'{ROW_ITEM, tbrl_pkg::CMD_QUERY, tbrl_pkg::REG_CAPACITY, 48'd2, 4'd1,
			1'b1, '{1'b0, 16'd0, 48'd5, 48'd2}},
		'{ROW_ITEM, tbrl_pkg::CMD_REQUEST, tbrl_pkg::REG_CAPACITY, 48'd3, 4'd1,
			1'b1, '{1'b0, 16'd0, 48'd5, 48'd3}},
		// fractional rate: a quarter token per ms
		'{ROW_WRITE, tbrl_pkg::CMD_QUERY, tbrl_pkg::REG_CAPACITY, 48'd16, 4'd0,
			1'b0, NO_WANT},
		'{ROW_WRITE, tbrl_pkg::CMD_QUERY, tbrl_pkg::REG_TOKEN_RATE, 48'h4000, 4'd0,
			1'b0, NO_WANT},
		'{ROW_ITEM, tbrl_pkg::CMD_REQUEST, tbrl_pkg::REG_CAPACITY, 48'd7, 4'd1,
			1'b0, NO_WANT},
		'{ROW_ITEM, tbrl_pkg::CMD_REQUEST, tbrl_pkg::REG_CAPACITY, 48'd8, 4'd1,
			1'b0, NO_WANT}
	};

	localparam logic [tbrl_pkg::CAP_W-1:0]  PHASE_CAP  [PHASES] =
		'{16'd16, 16'd0, 16'd65535, 16'd8, 16'd5, 16'd0};
	localparam logic [tbrl_pkg::RATE_W-1:0] PHASE_RATE [PHASES] =
		'{32'h0001_0000, 32'h0000_1000, 32'hFFFF_FFFF, 32'h0, 32'h0000_5555, 32'h0};

	logic clk;
	logic arst_n;

	tbrl_item_if #(.TIME_BITS(TIME_W))    item_ch ();
	tbrl_result_if #(.COUNT_BITS(COUNT_W)) result_ch ();
	tbrl_cfg_if                            cfg_ch ();

	token_bucket_rate_limiter_core #(
		.FRAC_BITS(FRAC_W),
		.TIME_BITS(TIME_W),
		.COUNT_BITS(COUNT_W)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.item(item_ch),
		.result(result_ch),
		.cfg(cfg_ch)
	);

	// Result words still owed by the block, oldest first.
	bucket_word_t pending_words [$];
	int           mismatch_count;
	int unsigned  cycle_count;
	bit           hold_ask;

	// Shadow of the bucket: registers and state as the block should hold them.
	logic [tbrl_pkg::CAP_W-1:0]   cap_now;
	logic [tbrl_pkg::RATE_W-1:0]  rate_now;
	logic [63:0]                  level_q;
	logic [TIME_W-1:0]            last_ms;
	bit                           baseline_ok;
	logic [COUNT_W-1:0]           grants;
	logic [COUNT_W-1:0]           refusals;

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Stop a hung run.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > LIMIT_CYCLES) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	function automatic logic [COUNT_W-1:0] count_up(input logic [COUNT_W-1:0] c);
		return (c == '1) ? c : c + 1'b1;
	endfunction

	// Advance the bucket to time t: set the baseline, follow a backward step,
	// or add elapsed * rate, holding the level at the capacity.
	function automatic void bucket_refill(input logic [TIME_W-1:0] t);
		logic [TIME_W-1:0] span;
		logic [63:0]       full_q;
		if (!baseline_ok) begin
			last_ms = t;
			baseline_ok = 1'b1;
		end else if (t < last_ms) begin
			last_ms = t;
		end else if (t != last_ms) begin
			span = t - last_ms;
			full_q = 64'(cap_now) << FRAC_W;
			// compare by division first so the product never overflows
			if (rate_now != '0 && 64'(span) > full_q / 64'(rate_now)) begin
				level_q = full_q;
			end else begin
				level_q = level_q + 64'(span) * 64'(rate_now);
				if (level_q > full_q)
					level_q = full_q;
			end
			last_ms = t;
		end
	endfunction

	// Work out the result word of one command and move the shadow state on.
	function automatic bucket_word_t bucket_step(input logic [tbrl_pkg::CMD_W-1:0] c,
			input logic [TIME_W-1:0] t);
		bucket_word_t w;
		logic [63:0]  one_token;
		one_token = 64'd1 << FRAC_W;
		w.allowed = 1'b0;
		case (c)
			tbrl_pkg::CMD_REQUEST: begin
				bucket_refill(t);
				if (level_q >= one_token) begin
					level_q = level_q - one_token;
					grants = count_up(grants);
					w.allowed = 1'b1;
				end else begin
					refusals = count_up(refusals);
				end
			end
			tbrl_pkg::CMD_QUERY: begin
				bucket_refill(t);
			end
			tbrl_pkg::CMD_RESET: begin
				level_q = 64'(cap_now) << FRAC_W;
				baseline_ok = 1'b0;
				grants = '0;
				refusals = '0;
			end
			default: begin
				// unused code: report only
			end
		endcase
		w.available = level_q[FRAC_W +: tbrl_pkg::CAP_W];
		w.allowed_total = grants;
		w.rejected_total = refusals;
		return w;
	endfunction

	task automatic flag_mismatch(input string what, input bucket_word_t want,
			input bucket_word_t got);
		mismatch_count++;
		if (mismatch_count <= LOUD_LIMIT)
			$display("mismatch %0d at cycle %0d (%s): expected %0d/%0d/%0d/%0d, got %0d/%0d/%0d/%0d",
				mismatch_count, cycle_count, what,
				want.allowed, want.available, want.allowed_total, want.rejected_total,
				got.allowed, got.available, got.allowed_total, got.rejected_total);
	endtask

	// Check every result word taken against the oldest expectation.
	always @(posedge clk) begin : result_check
		bucket_word_t got;
		bucket_word_t want;
		if (arst_n && result_ch.valid && result_ch.ready) begin
			got.allowed = result_ch.allowed;
			got.available = result_ch.available;
			got.allowed_total = result_ch.allowed_total;
			got.rejected_total = result_ch.rejected_total;
			if (pending_words.size() == 0) begin
				flag_mismatch("word with nothing expected", NO_WANT, got);
			end else begin
				want = pending_words.pop_front();
				if (got.allowed !== want.allowed || got.available !== want.available
						|| got.allowed_total !== want.allowed_total
						|| got.rejected_total !== want.rejected_total)
					flag_mismatch("allowed/available/granted/refused", want, got);
			end
		end
	end

	// Receiver: stretches of random length in one stall pattern each; a hold
	// request from the stimulus side stalls it outright.
	initial begin : receiver
		rx_mode_t mode;
		int       stretch_left;
		int       hold_left;
		logic     rdy;
		stretch_left = 0;
		hold_left = 0;
		mode = RX_OPEN;
		rdy = 1'b0;
		forever begin
			if (hold_ask) begin
				hold_ask = 1'b0;
				hold_left = HOLD_CYCLES;
			end
			if (stretch_left == 0) begin
				mode = rx_mode_t'($urandom_range(0, 3));
				stretch_left = $urandom_range(5, 60);
			end
			stretch_left--;
			if (hold_left > 0) begin
				hold_left--;
				rdy = 1'b0;
			end else begin
				case (mode)
					RX_OPEN:   rdy = 1'b1;
					RX_COIN:   rdy = ($urandom_range(0, 1) == 1);
					RX_SPARSE: rdy = ($urandom_range(0, 3) == 0);
					default:   rdy = ~rdy;
				endcase
			end
			result_ch.ready <= rdy;
			@(posedge clk);
		end
	end

	// Offer one word and hold it until taken, then log what must come back.
	task automatic offer_word(input logic [tbrl_pkg::CMD_W-1:0] c,
			input logic [TIME_W-1:0] t,
			input bit typed, input bucket_word_t typed_word);
		bucket_word_t predicted;
		item_ch.valid <= 1'b1;
		item_ch.cmd <= c;
		item_ch.now_ms <= t;
		@(posedge clk);
		while (!item_ch.ready)
			@(posedge clk);
		predicted = bucket_step(c, t);
		pending_words.push_back(typed ? typed_word : predicted);
	endtask

	task automatic idle_cycles(input int n);
		if (n != 0) begin
			item_ch.valid <= 1'b0;
			repeat (n) @(posedge clk);
		end
	endtask

	// Stop sending and wait until every owed word is out, then let the pipe settle.
	task automatic drain();
		item_ch.valid <= 1'b0;
		while (pending_words.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input tbrl_pkg::reg_idx_t idx,
			input logic [tbrl_pkg::CFG_DATA_W-1:0] data);
		drain();
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data <= data;
		@(posedge clk);
		while (!cfg_ch.ready)
			@(posedge clk);
		if (idx == tbrl_pkg::REG_CAPACITY)
			cap_now = data[tbrl_pkg::CAP_W-1:0];
		else
			rate_now = data[tbrl_pkg::RATE_W-1:0];
		cfg_ch.valid <= 1'b0;
	endtask

	initial begin : stimulus
		int                            row;
		int                            rep;
		int                            ph;
		int                            n;
		int                            burst_left;
		int                            pick;
		logic [TIME_W-1:0]             clock_ms;
		logic [tbrl_pkg::CMD_W-1:0]    c;
		logic [tbrl_pkg::CAP_W-1:0]    ph_cap;
		logic [tbrl_pkg::RATE_W-1:0]   ph_rate;

		// drive every input known from time zero
		arst_n <= 1'b0;
		item_ch.valid <= 1'b0;
		item_ch.cmd <= tbrl_pkg::CMD_QUERY;
		item_ch.now_ms <= '0;
		cfg_ch.valid <= 1'b0;
		cfg_ch.index <= tbrl_pkg::REG_CAPACITY;
		cfg_ch.data <= '0;
		hold_ask = 1'b0;
		mismatch_count = 0;
		cycle_count = 0;

		// shadow state after reset
		cap_now = tbrl_pkg::CAPACITY_RST;
		rate_now = tbrl_pkg::TOKEN_RATE_RST;
		level_q = 64'(tbrl_pkg::CAPACITY_RST) << FRAC_W;
		last_ms = '0;
		baseline_ok = 1'b0;
		grants = '0;
		refusals = '0;

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// walk the directed plan
		for (row = 0; row < $size(DIRECTED); row++) begin
			if (DIRECTED[row].kind == ROW_WRITE) begin
				write_reg(DIRECTED[row].idx,
					DIRECTED[row].value[tbrl_pkg::CFG_DATA_W-1:0]);
			end else begin
				for (rep = 0; rep < DIRECTED[row].reps; rep++) begin
					offer_word(DIRECTED[row].cmd, DIRECTED[row].value,
						DIRECTED[row].typed, DIRECTED[row].want);
					idle_cycles($urandom_range(0, 2));
				end
			end
		end

		// Random phases, one register setting each. Time mostly creeps forward
		// from a random base so the bucket hovers between empty and full.
		burst_left = $urandom_range(1, 24);
		for (ph = 0; ph < PHASES; ph++) begin
			ph_cap = (ph == PHASES - 1) ?
				tbrl_pkg::CAP_W'($urandom_range(1, 40)) : PHASE_CAP[ph];
			ph_rate = (ph == PHASES - 1) ?
				$urandom_range(32'h800, 32'h2_0000) : PHASE_RATE[ph];
			write_reg(tbrl_pkg::REG_CAPACITY, tbrl_pkg::CFG_DATA_W'(ph_cap));
			write_reg(tbrl_pkg::REG_TOKEN_RATE, ph_rate);
			clock_ms = {16'($urandom), $urandom};
			for (n = 0; n < PHASE_WORDS; n++) begin
				// back up the receiver so the block fills and stalls its input
				if (n == 40 && (ph == 1 || ph == 4))
					hold_ask = 1'b1;
				// hold off the sender until everything owed is out
				if (n == 80 && ph == 2)
					drain();

				pick = $urandom_range(0, 99);
				if (pick < 74)
					c = tbrl_pkg::CMD_REQUEST;
				else if (pick < 90)
					c = tbrl_pkg::CMD_QUERY;
				else if (pick < 95)
					c = tbrl_pkg::CMD_RESET;
				else
					c = CMD_SPARE;

				pick = $urandom_range(0, 99);
				if (pick < 70)
					clock_ms = clock_ms + $urandom_range(1, 3);
				else if (pick < 82)
					clock_ms = clock_ms;
				else if (pick < 88)
					clock_ms = clock_ms - $urandom_range(1, 50);
				else if (pick < 94)
					clock_ms = clock_ms + $urandom_range(4, 5000);
				else
					clock_ms = {16'($urandom), $urandom};

				offer_word(c, clock_ms, 1'b0, NO_WANT);

				// sender bursts with random gaps; some gaps are zero
				if (burst_left == 0) begin
					idle_cycles(($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8));
					burst_left = $urandom_range(1, 24);
				end else begin
					burst_left--;
				end
			end
		end

		drain();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (mismatch_count == 0 && pending_words.size() == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

@@ token_bucket_rate_limiter_core.f @@
+incdir+rtl
rtl/tbrl_pkg.sv
rtl/tbrl_item_if.sv
rtl/tbrl_result_if.sv
rtl/tbrl_cfg_if.sv
rtl/tbrl_bucket.sv
rtl/token_bucket_rate_limiter_core.sv
verif/token_bucket_rate_limiter_core_test.sv
